// File: src/dtpq_pkg.sv
// dtpq_pkg: types, codes and key compare for the deadline timer queue
// no dependencies; imported by dtpq_cell and the core top level
`timescale 1ns / 1ps

package dtpq_pkg;

    // fixed field widths
    localparam int TIME_W  = 48;
    localparam int DELAY_W = 32;
    localparam int TAG_W   = 16;
    localparam int ORDER_W = 32;
    localparam int COUNT_W = 7;

    // most expired words given by one advance
    localparam int MAX_OUT = 64;
    localparam int POP_W   = $clog2(MAX_OUT + 1);

    // operation codes of an input word
    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_ADVANCE  = 2'd1;
    localparam logic [1:0] OP_CANCEL   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SCHEDULED = 2'd0;
    localparam logic [1:0] KIND_EXPIRED   = 2'd1;
    localparam logic [1:0] KIND_NONE_DUE  = 2'd2;
    localparam logic [1:0] KIND_CANCELLED = 2'd3;

    // cell commands
    localparam int CELL_OP_W = 2;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD    = 2'd0;
    localparam logic [CELL_OP_W-1:0] CELL_INSERT  = 2'd1;
    localparam logic [CELL_OP_W-1:0] CELL_SHIFT   = 2'd2;
    localparam logic [CELL_OP_W-1:0] CELL_COMPACT = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [ORDER_W-1:0] order;
        logic [TAG_W-1:0]   tag;
    } key_t;

    typedef struct packed {
        logic valid;
        key_t key;
    } entry_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic [CELL_OP_W-1:0] op;
        entry_t               key;
    } cell_cmd_t;

    localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, key: '0};
    // stands left of the first cell: always occupied
    localparam entry_t ENTRY_EDGE  = '{valid: 1'b1, key: '0};

    // earlier deadline first, then lower order number
    function automatic logic key_less(key_t a, key_t b);
        key_less = {a.deadline, a.order} < {b.deadline, b.order};
    endfunction

endpackage

// File: src/dtpq_cell.sv
// dtpq_cell: one slot of the sorted timer chain
// depends on dtpq_pkg; instantiated in a row by the core top level
`timescale 1ns / 1ps

module dtpq_cell
    import dtpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  entry_t    left_entry,
    input  logic      left_gt,
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      gt
);

    logic   valid_reg;
    key_t   key_reg;
    entry_t entry_next;

    assign entry = '{valid: valid_reg, key: key_reg};

    // new key belongs ahead of this slot
    assign gt = !valid_reg || key_less(cmd.key.key, key_reg);

    // next slot contents
    always_comb
    begin
        unique case (cmd.op)
            CELL_HOLD:
            begin
                entry_next = entry;
            end
            CELL_INSERT:
            begin
                if (!gt)
                begin
                    entry_next = entry;
                end
                else if (left_gt)
                begin
                    entry_next = left_entry;
                end
                else
                begin
                    entry_next = cmd.key;
                end
            end
            CELL_SHIFT:
            begin
                entry_next = right_entry;
            end
            CELL_COMPACT:
            begin
                // holes move right one slot a cycle
                if (!valid_reg)
                begin
                    entry_next = right_entry;
                end
                else if (!left_entry.valid)
                begin
                    entry_next = ENTRY_EMPTY;
                end
                else
                begin
                    entry_next = entry;
                end
            end
        endcase
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    // key payload
    always_ff @(posedge clk)
    begin
        key_reg <= entry_next.key;
    end

endmodule

// File: src/deadline_timer_priority_queue_core.sv
// deadline_timer_priority_queue_core: timer queue kept sorted in a chain of cells
// depends on dtpq_pkg and dtpq_cell
`timescale 1ns / 1ps

// Usage
//   Input words carry operation, time_now, delay_ms and timer_tag on the
//   in_valid / in_stall channel; results leave on out_valid / out_stall with
//   result_kind, out_tag, due_time, removed_count, pending_count, overflow
//   and last. Every input word gets its results in order, last set on the
//   final one; an unused operation code gives no result.
//   Entries sit in CAPACITY cells sorted by deadline and order number, so
//   the earliest timer is always in the first cell.
//   Steps from acceptance to the result being loaded:
//     schedule: deadline add, then insert into the chain
//     advance:  one expired word per cycle while the output is free, or one none-due word
//     cancel:   one full rotation of the chain checks every tag at the
//               head, one compaction pass closes the holes
//   The cancel passes through the chain set the worst case. in_stall is
//   high while a word is at work.
//   A stalled result holds in the output register; the core waits before
//   giving the next one but takes a new input word as soon as it is idle.
//   Reset empties every cell and clears the entry count and order counter.

module deadline_timer_priority_queue_core
    import dtpq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [TIME_W-1:0]  time_now,
    input  logic [DELAY_W-1:0] delay_ms,
    input  logic [TAG_W-1:0]   timer_tag,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_kind,
    output logic [TAG_W-1:0]   out_tag,
    output logic [TIME_W-1:0]  due_time,
    output logic [COUNT_W-1:0] removed_count,
    output logic [COUNT_W-1:0] pending_count,
    output logic               overflow,
    output logic               last
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = $clog2(CAPACITY);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCH_ADD  = 3'd1;
    localparam logic [2:0] S_SCH_INS  = 3'd2;
    localparam logic [2:0] S_ADV      = 3'd3;
    localparam logic [2:0] S_CAN_ROT  = 3'd4;
    localparam logic [2:0] S_CAN_CMP  = 3'd5;
    localparam logic [2:0] S_CAN_DONE = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ORDER_W-1:0] order_reg, order_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;
    logic [POP_W-1:0]   pop_reg, pop_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;

    // request payload
    logic [TIME_W-1:0]  now_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [TAG_W-1:0]   tag_reg;

    // output register
    logic               out_valid_reg;
    logic [1:0]         kind_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [TIME_W-1:0]  due_reg;
    logic [COUNT_W-1:0] removed_out_reg;
    logic [COUNT_W-1:0] pending_out_reg;
    logic               ovf_reg;
    logic               last_reg;

    // word being loaded
    logic               emit;
    logic [1:0]         e_kind;
    logic [TAG_W-1:0]   e_tag;
    logic [TIME_W-1:0]  e_due;
    logic [CNT_W-1:0]   e_removed;
    logic [CNT_W-1:0]   e_pending;
    logic               e_ovf;
    logic               e_last;

    logic               in_accept;
    logic               out_free;
    logic [TIME_W:0]    sum_wide;
    logic               head_due;
    logic               next_due;
    logic               head_kill;
    logic               step_end;

    cell_cmd_t          cmd;
    entry_t             tail_in;
    entry_t             cells [CAPACITY];
    logic               gts [CAPACITY];

    assign in_stall  = state_reg != S_IDLE;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign sum_wide  = {1'b0, now_reg} + (TIME_W + 1)'(delay_reg);
    assign head_due  = cells[0].valid && (cells[0].key.deadline <= now_reg);
    assign next_due  = cells[1].valid && (cells[1].key.deadline <= now_reg)
                       && (pop_reg < POP_W'(MAX_OUT - 1));
    assign head_kill = cells[0].valid && (cells[0].key.tag == tag_reg);
    assign step_end  = step_reg == STEP_W'(CAPACITY - 1);

    // sorted chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_g;

        if (i == 0)
        begin : g_first
            assign left_e = ENTRY_EDGE;
            assign left_g = 1'b0;
        end
        else
        begin : g_inner_left
            assign left_e = cells[i-1];
            assign left_g = gts[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_e = tail_in;
        end
        else
        begin : g_inner_right
            assign right_e = cells[i+1];
        end

        dtpq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_gt     (left_g),
            .right_entry (right_e),
            .entry       (cells[i]),
            .gt          (gts[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        order_next    = order_reg;
        step_next     = step_reg;
        removed_next  = removed_reg;
        pop_next      = pop_reg;
        deadline_next = deadline_reg;
        cmd.op        = CELL_HOLD;
        cmd.key       = '{valid: 1'b1,
                          key: '{deadline: deadline_reg, order: order_reg, tag: tag_reg}};
        tail_in       = ENTRY_EMPTY;
        emit          = 1'b0;
        e_kind        = KIND_SCHEDULED;
        e_tag         = tag_reg;
        e_due         = '0;
        e_removed     = '0;
        e_pending     = count_reg;
        e_ovf         = 1'b0;
        e_last        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (operation)
                        OP_SCHEDULE:
                        begin
                            state_next = S_SCH_ADD;
                        end
                        OP_ADVANCE:
                        begin
                            state_next = S_ADV;
                            pop_next   = '0;
                        end
                        OP_CANCEL:
                        begin
                            state_next   = S_CAN_ROT;
                            step_next    = '0;
                            removed_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCH_ADD:
            begin
                // saturate at the top of the time range
                deadline_next = sum_wide[TIME_W] ? {TIME_W{1'b1}} : sum_wide[TIME_W-1:0];
                state_next    = S_SCH_INS;
            end
            S_SCH_INS:
            begin
                if (out_free)
                begin
                    emit  = 1'b1;
                    e_due = deadline_reg;
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        e_ovf = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                        order_next = order_reg + 1'b1;
                        e_pending  = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ADV:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (head_due)
                    begin
                        cmd.op     = CELL_SHIFT;
                        count_next = count_reg - 1'b1;
                        pop_next   = pop_reg + 1'b1;
                        e_kind     = KIND_EXPIRED;
                        e_tag      = cells[0].key.tag;
                        e_due      = cells[0].key.deadline;
                        e_pending  = count_reg - 1'b1;
                        e_last     = !next_due;
                        if (!next_due)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        e_kind     = KIND_NONE_DUE;
                        e_tag      = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CAN_ROT:
            begin
                // head goes round to the tail unless its tag matches
                cmd.op    = CELL_SHIFT;
                tail_in   = head_kill ? ENTRY_EMPTY : cells[0];
                step_next = step_reg + 1'b1;
                if (head_kill)
                begin
                    removed_next = removed_reg + 1'b1;
                end
                if (step_end)
                begin
                    step_next  = '0;
                    state_next = S_CAN_CMP;
                end
            end
            S_CAN_CMP:
            begin
                cmd.op    = CELL_COMPACT;
                step_next = step_reg + 1'b1;
                if (step_end)
                begin
                    step_next  = '0;
                    state_next = S_CAN_DONE;
                end
            end
            S_CAN_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_kind     = KIND_CANCELLED;
                    e_removed  = removed_reg;
                    e_pending  = count_reg - removed_reg;
                    count_next = count_reg - removed_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            order_reg     <= '0;
            step_reg      <= '0;
            removed_reg   <= '0;
            pop_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            order_reg   <= order_next;
            step_reg    <= step_next;
            removed_reg <= removed_next;
            pop_reg     <= pop_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture and deadline
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_reg   <= time_now;
            delay_reg <= delay_ms;
            tag_reg   <= timer_tag;
        end
        deadline_reg <= deadline_next;
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg        <= e_kind;
            out_tag_reg     <= e_tag;
            due_reg         <= e_due;
            removed_out_reg <= COUNT_W'(e_removed);
            pending_out_reg <= COUNT_W'(e_pending);
            ovf_reg         <= e_ovf;
            last_reg        <= e_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign out_tag       = out_tag_reg;
    assign due_time      = due_reg;
    assign removed_count = removed_out_reg;
    assign pending_count = pending_out_reg;
    assign overflow      = ovf_reg;
    assign last          = last_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cells[0].valid == (count_reg != '0)))
        else $error("head cell occupancy disagrees with entry count");

    a_tail_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && cells[CAPACITY-1].valid) |-> (count_reg == CNT_W'(CAPACITY)))
        else $error("tail cell occupied while chain not full");

    a_expired_due: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_kind == KIND_EXPIRED) |-> (e_due <= now_reg))
        else $error("expired word with deadline after current time");

    a_order_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCH_INS) |=> $stable(order_reg))
        else $error("order counter moved outside an insert");

endmodule
